[hw/rtl/dbc_pkg.sv]
// Shared types and character codes for the delimiter balance classifier.
package dbc_pkg;

  typedef enum logic [1:0] {
    VerdictEmpty      = 2'd0,
    VerdictMeta       = 2'd1,
    VerdictIncomplete = 2'd2,
    VerdictComplete   = 2'd3
  } verdict_e;

  // scanner context flags
  typedef struct packed {
    logic inside_string;
    logic escape_pending;
    logic inside_comment;
    logic slash_seen;
    logic saw_nonspace;
    logic starts_with_dot;
  } scan_flags_t;

  localparam logic [7:0] CharLbrace    = 8'h7B;
  localparam logic [7:0] CharRbrace    = 8'h7D;
  localparam logic [7:0] CharLparen    = 8'h28;
  localparam logic [7:0] CharRparen    = 8'h29;
  localparam logic [7:0] CharLsquare   = 8'h5B;
  localparam logic [7:0] CharRsquare   = 8'h5D;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharDot       = 8'h2E;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharCr        = 8'h0D;

endpackage

[hw/rtl/dbc_scan.sv]
// Per-word next-state and verdict logic of the delimiter scanner.
module dbc_scan #(
  parameter int DEPTH_BITS = 16
) (
  input  dbc_pkg::scan_flags_t           flags_q_i,
  input  logic signed [DEPTH_BITS-1:0]   brace_q_i,
  input  logic signed [DEPTH_BITS-1:0]   paren_q_i,
  input  logic signed [DEPTH_BITS-1:0]   square_q_i,
  input  logic [7:0]                     char_byte_i,
  input  logic                           has_byte_i,
  output dbc_pkg::scan_flags_t           flags_d_o,
  output logic signed [DEPTH_BITS-1:0]   brace_d_o,
  output logic signed [DEPTH_BITS-1:0]   paren_d_o,
  output logic signed [DEPTH_BITS-1:0]   square_d_o,
  output dbc_pkg::verdict_e              verdict_o
);
  import dbc_pkg::*;

  localparam logic signed [DEPTH_BITS-1:0] DepthMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DepthMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic signed [DEPTH_BITS-1:0] DepthOne = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

  function automatic logic signed [DEPTH_BITS-1:0] bump(
    input logic signed [DEPTH_BITS-1:0] v, input logic up);
    logic signed [DEPTH_BITS-1:0] r;
    if (up) begin
      r = (v == DepthMax) ? v : v + DepthOne;
    end else begin
      r = (v == DepthMin) ? v : v - DepthOne;
    end
    return r;
  endfunction

  function automatic logic positive(input logic signed [DEPTH_BITS-1:0] v);
    return !v[DEPTH_BITS-1] && (v != '0);
  endfunction

  logic is_ws;

  assign is_ws = (char_byte_i == CharSpace) ||
                 ((char_byte_i >= CharTab) && (char_byte_i <= CharCr));

  always_comb begin
    flags_d_o  = flags_q_i;
    brace_d_o  = brace_q_i;
    paren_d_o  = paren_q_i;
    square_d_o = square_q_i;
    if (has_byte_i) begin
      if (!flags_q_i.saw_nonspace && !is_ws) begin
        flags_d_o.saw_nonspace    = 1'b1;
        flags_d_o.starts_with_dot = (char_byte_i == CharDot);
      end
      if (flags_q_i.inside_comment) begin
        if (char_byte_i == CharNewline) begin
          flags_d_o.inside_comment = 1'b0;
        end
      end else if (flags_q_i.escape_pending) begin
        flags_d_o.escape_pending = 1'b0;
      end else if (flags_q_i.inside_string) begin
        if (char_byte_i == CharBackslash) begin
          flags_d_o.escape_pending = 1'b1;
        end else if (char_byte_i == CharQuote) begin
          flags_d_o.inside_string = 1'b0;
        end
      end else if (char_byte_i == CharSlash) begin
        // second slash opens a line comment
        flags_d_o.slash_seen     = !flags_q_i.slash_seen;
        flags_d_o.inside_comment = flags_q_i.slash_seen;
      end else begin
        flags_d_o.slash_seen = 1'b0;
        case (char_byte_i)
          CharQuote:   flags_d_o.inside_string = 1'b1;
          CharLbrace:  brace_d_o  = bump(brace_q_i, 1'b1);
          CharRbrace:  brace_d_o  = bump(brace_q_i, 1'b0);
          CharLparen:  paren_d_o  = bump(paren_q_i, 1'b1);
          CharRparen:  paren_d_o  = bump(paren_q_i, 1'b0);
          CharLsquare: square_d_o = bump(square_q_i, 1'b1);
          CharRsquare: square_d_o = bump(square_q_i, 1'b0);
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (!flags_d_o.saw_nonspace) begin
      verdict_o = VerdictEmpty;
    end else if (flags_d_o.starts_with_dot) begin
      verdict_o = VerdictMeta;
    end else if (flags_d_o.inside_string || positive(brace_d_o) ||
                 positive(paren_d_o) || positive(square_d_o)) begin
      verdict_o = VerdictIncomplete;
    end else begin
      verdict_o = VerdictComplete;
    end
  end

endmodule

[hw/rtl/dbc_obuf.sv]
// Two-entry result buffer: output register plus skid slot.
module dbc_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dbc_pkg::verdict_e push_verdict_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dbc_pkg::verdict_e out_verdict_o
);
  import dbc_pkg::*;

  logic     out_valid_q, skid_valid_q;
  verdict_e out_q, skid_q;
  logic     out_fire;

  assign out_fire      = out_valid_q && out_ready_i;
  assign space_o       = !skid_valid_q;
  assign out_valid_o   = out_valid_q;
  assign out_verdict_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_q <= push_verdict_i;
      end else begin
        skid_q <= push_verdict_i;
      end
    end
  end

endmodule

[hw/rtl/delimiter_balance_classifier.sv]
// Top level of the delimiter balance classifier: scan state, handshakes, checks.
// Takes a text one byte per word and, on the word marked last, returns one
// verdict: empty (only whitespace), meta command (first non-whitespace byte is
// a dot), incomplete (an open string or a positive brace, parenthesis or
// bracket depth) or complete. Strings in double quotes, with backslash
// escapes, and // line comments are skipped for depth counting. Depths are
// signed DEPTH_BITS-bit counters that saturate. A last word with has_byte_i
// low closes a submission without a byte; one without last does nothing.
// Throughput is one word per clock: dbc_scan computes the next scan state
// combinationally, and verdicts go into a two-deep output buffer, so
// in_ready_o drops only while both buffer slots hold untaken verdicts.
// A last word's verdict appears on the output in the cycle after it when the
// output register is free; otherwise the verdict waits in the skid slot until
// the one ahead of it is taken.
module delimiter_balance_classifier #(
  parameter int DEPTH_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       has_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] verdict_o
);
  import dbc_pkg::*;

  scan_flags_t                  flags_q, flags_d;
  logic signed [DEPTH_BITS-1:0] brace_q, brace_d;
  logic signed [DEPTH_BITS-1:0] paren_q, paren_d;
  logic signed [DEPTH_BITS-1:0] square_q, square_d;
  verdict_e                     verdict_new, verdict_out;
  logic                         in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  dbc_scan #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_scan (
    .flags_q_i  (flags_q),
    .brace_q_i  (brace_q),
    .paren_q_i  (paren_q),
    .square_q_i (square_q),
    .char_byte_i(char_byte_i),
    .has_byte_i (has_byte_i),
    .flags_d_o  (flags_d),
    .brace_d_o  (brace_d),
    .paren_d_o  (paren_d),
    .square_d_o (square_d),
    .verdict_o  (verdict_new)
  );

  // scan state: takes the next value on each word, clears after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      brace_q  <= '0;
      paren_q  <= '0;
      square_q <= '0;
    end else if (in_fire) begin
      if (last_i) begin
        flags_q  <= '0;
        brace_q  <= '0;
        paren_q  <= '0;
        square_q <= '0;
      end else begin
        flags_q  <= flags_d;
        brace_q  <= brace_d;
        paren_q  <= paren_d;
        square_q <= square_d;
      end
    end
  end

  dbc_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (in_fire && last_i),
    .push_verdict_i(verdict_new),
    .space_o       (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_verdict_o (verdict_out)
  );

  assign verdict_o = verdict_out;

  // a last word always leaves a verdict pending on the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_i |=> out_valid_o)
    else $error("verdict lost after last word");

  // all scan state is cleared after a last word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_i |=> (flags_q == '0) && (brace_q == '0) &&
                          (paren_q == '0) && (square_q == '0))
    else $error("scan state not cleared after last word");

  // an escape is only pending inside a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.escape_pending |-> flags_q.inside_string)
    else $error("escape pending outside string");

  // string and comment contexts exclude each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flags_q.inside_string && flags_q.inside_comment))
    else $error("string and comment open together");

  // dot flag only once a non-whitespace byte was seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.starts_with_dot |-> flags_q.saw_nonspace)
    else $error("dot flag without non-whitespace byte");

endmodule
